[hdl/bcf_pkg.sv]
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types and constants of the bezier curve flattener: the fixed-point
// format of the curve parameter t and the point tag that runs along the
// interpolation pipeline.
// ----------------------------------------------------------------------------
package bcf_pkg;

   // curve parameter t: Q0.16 plus a unit bit, 65536 is 1.0
   localparam int T_FRAC = 16;
   localparam int T_W    = T_FRAC + 1;
   localparam logic [T_W-1:0] T_ONE = T_W'(1 << T_FRAC);
   localparam int T_HALF = 1 << (T_FRAC - 1);

   // segment count register and point index
   localparam int SEG_W = 7;
   localparam logic [SEG_W-1:0] SEG_RESET = 7'd32;
   localparam logic [SEG_W-1:0] SEG_MIN   = 7'd2;
   localparam int IDX_W = 6;

   // step-size divider: one quotient bit per cycle
   localparam int DIV_CNT_W = $clog2(T_W);

   // register stages from point issue to the output register
   localparam int PIPE_STAGES = 6;

   // tag that travels with every point
   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] index;
      logic             last;
   } bcf_meta_type;

endpackage

[hdl/bezier_curve_flattener.sv]
// ----------------------------------------------------------------------------
// bezier_curve_flattener
// Flattens quadratic and cubic bezier curves by de Casteljau interpolation
// at N evenly spaced t values, N being the clamped segment count.
// Each point is registered through the first, second and last interpolation
// levels on its way to its output beat. One point per cycle while the output
// beat is not held; a new curve is taken only once the held one is issued.
// Reset: segment count 32, then a step-size division with req_tready low;
// every csr write starts that division again.
// ----------------------------------------------------------------------------
module bezier_curve_flattener
   import bcf_pkg::*;
#(
   parameter int COORD_WIDTH  = 24,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   // req_tdata: p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
   input  logic [((8*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // req_tuser: mode
   input  logic                    req_tuser,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // rsp_tdata: point_x, point_y, point_index
   output logic [((2*COORD_WIDTH+IDX_W+7)/8)*8-1:0] rsp_tdata,
   output logic                    rsp_tlast,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic                    csr_wr_en,
   input  logic [SEG_W-1:0]        csr_wr_data
);

   localparam int CW = COORD_WIDTH;
   localparam int DW = $clog2(MAX_SEGMENTS);
   localparam int PW = 2 * CW + IDX_W;

   logic [SEG_W-1:0]       seg_ff;
   logic [SEG_W-1:0]       n_eff;
   logic [DW-1:0]          d;
   logic                   div_busy;
   logic [T_W-1:0]         t_step;
   logic [DW:0]            r_step;
   logic [3:0][CW-1:0]     in_px, in_py, cur_px, cur_py;
   logic                   seq_valid;
   logic [T_W-1:0]         seq_t;
   bcf_meta_type           seq_meta;
   logic                   en;
   logic                   v_ff [1:PIPE_STAGES];
   bcf_meta_type           meta_ff [1:PIPE_STAGES];
   logic [T_W-1:0]         t_ff [1:4];
   logic signed [CW-1:0]   l1x [3], l1y [3];
   logic signed [CW-1:0]   l2x [2], l2y [2];
   logic signed [CW-1:0]   l3x_b, l3y_b;
   logic signed [CW-1:0]   pt_x, pt_y;

   // segment count register
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= SEG_RESET;
      end else if (csr_wr_en) begin
         seg_ff <= csr_wr_data;
      end
   end

   // clamp the count, d is the number of intervals
   always_comb begin
      if (seg_ff < SEG_MIN) begin
         n_eff = SEG_MIN;
      end else if (seg_ff > SEG_W'(MAX_SEGMENTS)) begin
         n_eff = SEG_W'(MAX_SEGMENTS);
      end else begin
         n_eff = seg_ff;
      end
      d = DW'(n_eff - 1'b1);
   end

   bcf_step_div #(.DW(DW)) u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (csr_wr_en),
      .d      (d),
      .busy   (div_busy),
      .t_step (t_step),
      .r_step (r_step)
   );

   // unpack the control points
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         in_px[k] = req_tdata[(2*k)*CW +: CW];
         in_py[k] = req_tdata[(2*k+1)*CW +: CW];
      end
   end

   bcf_seq #(.CW(CW), .DW(DW)) u_seq (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_mode   (req_tuser),
      .in_px     (in_px),
      .in_py     (in_py),
      .d         (d),
      .div_busy  (div_busy),
      .t_step    (t_step),
      .r_step    (r_step),
      .out_valid (seq_valid),
      .out_t     (seq_t),
      .out_meta  (seq_meta),
      .out_px    (cur_px),
      .out_py    (cur_py)
   );

   // whole pipeline moves unless the output beat is held
   assign en = !v_ff[PIPE_STAGES] || rsp_tready;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= PIPE_STAGES; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (en) begin
         v_ff[1] <= seq_valid;
         for (int s = 2; s <= PIPE_STAGES; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   // point tag and t alongside the data
   always_ff @(posedge clock) begin
      if (en) begin
         meta_ff[1] <= seq_meta;
         for (int s = 2; s <= PIPE_STAGES; s++) begin
            meta_ff[s] <= meta_ff[s-1];
         end
         t_ff[1] <= seq_t;
         for (int s = 2; s <= 4; s++) begin
            t_ff[s] <= t_ff[s-1];
         end
      end
   end

   // first level: along the control polygon
   for (genvar k = 0; k < 3; k++) begin : g_lvl1
      bcf_lerp #(.CW(CW)) u_x (
         .clock (clock), .en (en), .a (cur_px[k]), .b (cur_px[k+1]),
         .t (seq_t), .y (l1x[k])
      );
      bcf_lerp #(.CW(CW)) u_y (
         .clock (clock), .en (en), .a (cur_py[k]), .b (cur_py[k+1]),
         .t (seq_t), .y (l1y[k])
      );
   end

   // second level
   for (genvar k = 0; k < 2; k++) begin : g_lvl2
      bcf_lerp #(.CW(CW)) u_x (
         .clock (clock), .en (en), .a (l1x[k]), .b (l1x[k+1]),
         .t (t_ff[2]), .y (l2x[k])
      );
      bcf_lerp #(.CW(CW)) u_y (
         .clock (clock), .en (en), .a (l1y[k]), .b (l1y[k+1]),
         .t (t_ff[2]), .y (l2y[k])
      );
   end

   // quadratic curves are done after two levels: last level sees a == b
   assign l3x_b = meta_ff[4].mode ? l2x[1] : l2x[0];
   assign l3y_b = meta_ff[4].mode ? l2y[1] : l2y[0];

   bcf_lerp #(.CW(CW)) u_lvl3_x (
      .clock (clock), .en (en), .a (l2x[0]), .b (l3x_b), .t (t_ff[4]), .y (pt_x)
   );
   bcf_lerp #(.CW(CW)) u_lvl3_y (
      .clock (clock), .en (en), .a (l2y[0]), .b (l3y_b), .t (t_ff[4]), .y (pt_y)
   );

   // output beat
   always_comb begin
      rsp_tdata         = '0;
      rsp_tdata[PW-1:0] = {meta_ff[PIPE_STAGES].index, pt_y, pt_x};
   end
   assign rsp_tlast  = meta_ff[PIPE_STAGES].last;
   assign rsp_tvalid = v_ff[PIPE_STAGES];

   // t lands exactly on 1.0 at the end point
   a_last_t_one: assert property (@(posedge clock) disable iff (reset)
      seq_valid && seq_meta.last |-> seq_t == T_ONE)
      else $error("end point issued with t other than one");

   // t starts at zero on the first point
   a_first_t_zero: assert property (@(posedge clock) disable iff (reset)
      seq_valid && (seq_meta.index == '0) |-> seq_t == '0)
      else $error("first point issued with nonzero t");

   // the marked beat closes the curve at the expected index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[PW-1:2*CW] == IDX_W'(d))
      else $error("last beat at wrong point index");

   // an accepted curve starts issuing points in the next cycle
   a_accept_issue: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> seq_valid && (seq_meta.index == '0))
      else $error("accepted curve not issued");

endmodule

[hdl/bcf_step_div.sv]
// ----------------------------------------------------------------------------
// bcf_step_div
// Restoring divider that works out 65536 / d, one quotient bit per cycle.
// The quotient is the per-point increment of t and twice the remainder is
// the per-point increment of the rounding residue.
// ----------------------------------------------------------------------------
module bcf_step_div
   import bcf_pkg::*;
#(
   parameter int DW = 6
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] d,
   output logic          busy,
   output logic [T_W-1:0] t_step,
   output logic [DW:0]   r_step
);

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(T_W - 1);

   logic                 run_ff, run_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]        rem_ff, rem_in;
   logic [T_W-1:0]       q_ff, q_in;
   logic [DW-1:0]        rem_cur;
   logic                 div_bit;
   logic [DW:0]          trial;
   logic                 q_bit;

   // one shift-and-subtract step, dividend is a one followed by zeros
   always_comb begin
      rem_cur = (cnt_ff == '0) ? '0 : rem_ff;
      div_bit = (cnt_ff == '0);
      trial   = {rem_cur, div_bit};
      q_bit   = (trial >= {1'b0, d});
      if (q_bit) begin
         rem_in = DW'(trial - {1'b0, d});
      end else begin
         rem_in = trial[DW-1:0];
      end
      q_in   = {q_ff[T_W-2:0], q_bit};
      cnt_in = cnt_ff + 1'b1;
      run_in = run_ff && (cnt_ff != LAST_STEP);
   end

   // control: a run starts at reset and on every register write
   always_ff @(posedge clock) begin
      if (reset || start) begin
         run_ff <= 1'b1;
         cnt_ff <= '0;
      end else if (run_ff) begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   // quotient and remainder
   always_ff @(posedge clock) begin
      if (run_ff) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign busy   = run_ff;
   assign t_step = q_ff;
   assign r_step = {rem_ff, 1'b0};

endmodule

[hdl/bcf_seq.sv]
// ----------------------------------------------------------------------------
// bcf_seq
// Point sequencer: holds one curve and issues its points one per cycle while en is high.
// t = round(i*65536/d) is stepped exactly by adding a quotient and carrying
// a residue kept below 2*d.
// ----------------------------------------------------------------------------
module bcf_seq
   import bcf_pkg::*;
#(
   parameter int CW = 24,
   parameter int DW = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 in_mode,
   input  logic [3:0][CW-1:0]   in_px,
   input  logic [3:0][CW-1:0]   in_py,
   input  logic [DW-1:0]        d,
   input  logic                 div_busy,
   input  logic [T_W-1:0]       t_step,
   input  logic [DW:0]          r_step,
   output logic                 out_valid,
   output logic [T_W-1:0]       out_t,
   output bcf_meta_type         out_meta,
   output logic [3:0][CW-1:0]   out_px,
   output logic [3:0][CW-1:0]   out_py
);

   logic                busy_ff;
   logic [DW-1:0]       i_ff;
   logic [T_W-1:0]      t_ff, t_in;
   logic [DW:0]         r_ff, r_in;
   logic                mode_ff;
   logic [3:0][CW-1:0]  px_ff, py_ff;
   logic                accept, adv, last;
   logic [DW+1:0]       r_sum, two_d;
   logic                wrap;

   assign in_ready = !busy_ff && !div_busy;
   assign accept   = in_valid && in_ready;
   assign adv      = busy_ff && en;
   assign last     = (i_ff == d);

   // next t and residue
   always_comb begin
      r_sum = {1'b0, r_ff} + {1'b0, r_step};
      two_d = {1'b0, d, 1'b0};
      wrap  = (r_sum >= two_d);
      if (wrap) begin
         r_in = (DW+1)'(r_sum - two_d);
      end else begin
         r_in = r_sum[DW:0];
      end
      t_in = t_ff + t_step + T_W'(wrap);
   end

   // busy while points of the held curve remain
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (adv && last) begin
         busy_ff <= 1'b0;
      end
   end

   // curve hold and point counter
   always_ff @(posedge clock) begin
      if (accept) begin
         i_ff    <= '0;
         t_ff    <= '0;
         r_ff    <= {1'b0, d};
         mode_ff <= in_mode;
         px_ff   <= in_px;
         py_ff   <= in_py;
      end else if (adv) begin
         i_ff <= i_ff + 1'b1;
         t_ff <= t_in;
         r_ff <= r_in;
      end
   end

   assign out_valid      = busy_ff;
   assign out_t          = t_ff;
   assign out_meta.mode  = mode_ff;
   assign out_meta.index = IDX_W'(i_ff);
   assign out_meta.last  = last;
   assign out_px         = px_ff;
   assign out_py         = py_ff;

endmodule

[hdl/bcf_lerp.sv]
// ----------------------------------------------------------------------------
// bcf_lerp
// One interpolation a + round((b-a)*t / 65536) over two register stages:
// difference and multiply, then round and add.
// ----------------------------------------------------------------------------
module bcf_lerp
   import bcf_pkg::*;
#(
   parameter int CW = 24
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW-1:0] a,
   input  logic signed [CW-1:0] b,
   input  logic [T_W-1:0]       t,
   output logic signed [CW-1:0] y
);

   localparam int PW = CW + T_W + 2;

   logic signed [CW:0]   diff;
   logic signed [PW-1:0] prod_in, prod_ff;
   logic signed [CW-1:0] a_ff, y_ff;
   logic signed [PW-1:0] rnd;
   logic [PW-T_FRAC-1:0] frac_q;

   // stage a: difference times t
   always_comb begin
      diff    = {b[CW-1], b} - {a[CW-1], a};
      prod_in = diff * $signed({1'b0, t});
   end

   // stage b: round half up and add back the base
   always_comb begin
      rnd    = prod_ff + PW'(T_HALF);
      frac_q = rnd[PW-1:T_FRAC];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff    <= a;
         prod_ff <= prod_in;
         y_ff    <= CW'(a_ff + frac_q);
      end
   end

   assign y = y_ff;

endmodule
